// ----- sv/line_tokenizer_with_groups_core_macros.svh -----
// ----------------------------------------------------------------------------
// Line tokenizer assertion macros
// Shared concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_TOKENIZER_WITH_GROUPS_CORE_MACROS_SVH
`define LINE_TOKENIZER_WITH_GROUPS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset
`define LTG_ASSERT_HOLDS(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) \
    else $error("ltg invariant violated");
// Consequent must hold in the cycle after the antecedent
`define LTG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ltg sequence check failed");
`else
`define LTG_ASSERT_HOLDS(lbl, clk_s, rst_s, expr)
`define LTG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- sv/ltg_pkg.sv -----
// ----------------------------------------------------------------------------
// Line tokenizer package
// Character codes, token kinds, register indexes and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ltg_pkg;

  // Line geometry
  localparam int MAX_LINE = 1024;
  localparam int POS_W    = 10;
  localparam int LEN_W    = 11;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE - 1);

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] SEP_RESET = 8'h20;

  // Token kinds
  localparam logic [2:0] KIND_PLAIN   = 3'd0;
  localparam logic [2:0] KIND_BRACKET = 3'd1;
  localparam logic [2:0] KIND_BRACE   = 3'd2;
  localparam logic [2:0] KIND_HEAD    = 3'd3;
  localparam logic [2:0] KIND_TAIL    = 3'd4;

  // Configuration register indexes
  localparam logic REG_SEPARATOR      = 1'b0;
  localparam logic REG_ALLOW_COMPOSED = 1'b1;

  typedef struct packed {
    logic [7:0] separator;
    logic       allow_composed;
  } cfg_t;

  typedef struct packed {
    logic             token_valid;
    logic [POS_W-1:0] token_offset;
    logic [LEN_W-1:0] token_length;
    logic [2:0]       token_kind;
    logic             line_done;
    logic             brace_error;
    logic             last_result;
  } res_t;

  // Up to two results written into the queue per byte transfer
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

// ----- sv/ltg_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Line tokenizer byte step
// Holds the line state and turns one transferred byte into zero to two results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_tokenizer_with_groups_core_macros.svh"

module ltg_tokenizer (
  input  logic           clk,
  input  logic           rst,
  input  ltg_pkg::cfg_t  cfg,
  input  logic           take,
  input  logic [7:0]     char_code,
  input  logic           last_char,
  output ltg_pkg::push_t push
);

  // Line state
  logic [ltg_pkg::POS_W-1:0] pos, pos_next;
  logic [ltg_pkg::POS_W-1:0] cur_start, cur_start_next;
  logic [ltg_pkg::LEN_W-1:0] cur_length, cur_length_next;
  logic [7:0]                first_byte, first_byte_next;
  logic [7:0]                second_byte, second_byte_next;
  logic [ltg_pkg::POS_W-1:0] dot_offset, dot_offset_next;
  logic                      dot_found, dot_found_next;
  logic [10:0]               brace_nesting, brace_nesting_next;
  logic [11:0]               brace_balance, brace_balance_next;
  logic                      first_pending, first_pending_next;
  logic                      stopped, stopped_next;

  // Byte classification
  logic drop, hash_start, work, is_open, is_close, plain_byte;
  logic in_brk, in_brc, keep_in, tok_end;
  logic [10:0] nest_inc, nest_after;
  logic [11:0] bal_byte, bal_fin;

  // Token after adding this byte
  logic [ltg_pkg::POS_W-1:0] start_a, dot_a;
  logic [ltg_pkg::LEN_W-1:0] len_a;
  logic [7:0]                first_a, second_a;
  logic                      found_a;
  logic emit, comment, brk_tok, brc_tok, split, tok_out;

  logic [1:0]    n;
  ltg_pkg::res_t r0, r1;

  assign drop       = !last_char && (pos >= ltg_pkg::POS_LIMIT);
  assign hash_start = (pos == '0) &&
                      ((char_code == ltg_pkg::CH_HASH) || (char_code == ltg_pkg::CH_BANG));
  assign work       = take && !drop && !stopped && !hash_start;

  assign is_open  = (char_code == ltg_pkg::CH_LBRC);
  assign is_close = (char_code == ltg_pkg::CH_RBRC);
  assign nest_inc = brace_nesting + {10'd0, is_open};
  assign bal_byte = brace_balance + {11'd0, is_open} - {11'd0, is_close};
  assign bal_fin  = work ? bal_byte : brace_balance;

  assign plain_byte = (char_code != cfg.separator) && (char_code != ltg_pkg::CH_TAB) &&
                      (char_code != ltg_pkg::CH_NL) && (char_code != ltg_pkg::CH_NUL);
  assign in_brk = (cur_length != '0) && (first_byte == ltg_pkg::CH_LBRK);
  assign in_brc = (cur_length != '0) && (first_byte == ltg_pkg::CH_LBRC);

  // Include / end decision per token type
  always_comb begin
    keep_in    = 1'b0;
    tok_end    = 1'b0;
    nest_after = nest_inc;
    if (in_brk) begin
      keep_in = 1'b1;
      tok_end = last_char || (char_code == ltg_pkg::CH_RBRK);
    end else if (in_brc) begin
      keep_in = 1'b1;
      if (last_char) begin
        tok_end = 1'b1;
      end else if (is_close) begin
        nest_after = nest_inc - 11'd1;
        tok_end    = (nest_after == '0);
      end
    end else begin
      keep_in = plain_byte;
      tok_end = !plain_byte || last_char;
    end
  end

  // Token registers with this byte appended
  assign start_a  = (keep_in && (cur_length == '0)) ? pos : cur_start;
  assign first_a  = (keep_in && (cur_length == '0)) ? char_code : first_byte;
  assign second_a = (keep_in && (cur_length == 11'd1)) ? char_code : second_byte;
  assign found_a  = dot_found || (keep_in && (char_code == ltg_pkg::CH_DOT));
  assign dot_a    = (dot_found || !keep_in) ? dot_offset : cur_length[ltg_pkg::POS_W-1:0];
  assign len_a    = keep_in ? (cur_length + 11'd1) : cur_length;

  assign emit    = work && tok_end && (len_a != '0);
  assign comment = (len_a > 11'd1) &&
                   (((first_a == ltg_pkg::CH_SLASH) && (second_a == ltg_pkg::CH_SLASH)) ||
                    ((first_a == ltg_pkg::CH_HASH) && (second_a == ltg_pkg::CH_HASH)));
  assign brk_tok = (len_a > 11'd1) && (first_a == ltg_pkg::CH_LBRK) &&
                   (char_code == ltg_pkg::CH_RBRK);
  assign brc_tok = (len_a > 11'd1) && (first_a == ltg_pkg::CH_LBRC) && is_close;
  assign split   = first_pending && cfg.allow_composed && found_a;
  assign tok_out = emit && !comment;

  // Result assembly
  always_comb begin
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    if (tok_out) begin
      n               = 2'd1;
      r0.token_valid  = 1'b1;
      r0.token_offset = start_a;
      r0.token_length = len_a;
      if (brk_tok) begin
        r0.token_kind = ltg_pkg::KIND_BRACKET;
      end else if (brc_tok) begin
        r0.token_kind = ltg_pkg::KIND_BRACE;
      end else if (split) begin
        n               = 2'd2;
        r0.token_length = {1'b0, dot_a};
        r0.token_kind   = ltg_pkg::KIND_HEAD;
        r1.token_valid  = 1'b1;
        r1.token_offset = start_a + dot_a + 10'd1;
        r1.token_length = len_a - {1'b0, dot_a} - 11'd1;
        r1.token_kind   = ltg_pkg::KIND_TAIL;
      end else begin
        r0.token_kind = ltg_pkg::KIND_PLAIN;
      end
    end
    // Line end always produces a result
    if (take && last_char) begin
      if (n == 2'd0) begin
        n = 2'd1;
      end
      if (n == 2'd2) begin
        r1.line_done   = 1'b1;
        r1.brace_error = (bal_fin != '0);
      end else begin
        r0.line_done   = 1'b1;
        r0.brace_error = (bal_fin != '0);
      end
    end
    if (n == 2'd2) begin
      r1.last_result = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  assign push.count = n;
  assign push.r0    = r0;
  assign push.r1    = r1;

  // Next line state
  always_comb begin
    pos_next           = pos;
    cur_start_next     = cur_start;
    cur_length_next    = cur_length;
    first_byte_next    = first_byte;
    second_byte_next   = second_byte;
    dot_offset_next    = dot_offset;
    dot_found_next     = dot_found;
    brace_nesting_next = brace_nesting;
    brace_balance_next = brace_balance;
    first_pending_next = first_pending;
    stopped_next       = stopped;
    if (take && !drop) begin
      if (last_char) begin
        pos_next           = '0;
        cur_start_next     = '0;
        cur_length_next    = '0;
        first_byte_next    = '0;
        second_byte_next   = '0;
        dot_offset_next    = '0;
        dot_found_next     = 1'b0;
        brace_nesting_next = '0;
        brace_balance_next = '0;
        first_pending_next = 1'b1;
        stopped_next       = 1'b0;
      end else begin
        pos_next = pos + 10'd1;
        if (!stopped && hash_start) begin
          stopped_next = 1'b1;
        end
        if (work) begin
          brace_nesting_next = nest_after;
          brace_balance_next = bal_byte;
          if (emit) begin
            cur_start_next   = '0;
            cur_length_next  = '0;
            first_byte_next  = '0;
            second_byte_next = '0;
            dot_offset_next  = '0;
            dot_found_next   = 1'b0;
            if (comment) begin
              stopped_next = 1'b1;
            end else begin
              first_pending_next = 1'b0;
              if ((char_code == ltg_pkg::CH_NL) || (char_code == ltg_pkg::CH_NUL)) begin
                stopped_next = 1'b1;
              end
            end
          end else begin
            cur_start_next   = start_a;
            cur_length_next  = len_a;
            first_byte_next  = first_a;
            second_byte_next = second_a;
            dot_offset_next  = dot_a;
            dot_found_next   = found_a;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      cur_start     <= '0;
      cur_length    <= '0;
      first_byte    <= '0;
      second_byte   <= '0;
      dot_offset    <= '0;
      dot_found     <= 1'b0;
      brace_nesting <= '0;
      brace_balance <= '0;
      first_pending <= 1'b1;
      stopped       <= 1'b0;
    end else begin
      pos           <= pos_next;
      cur_start     <= cur_start_next;
      cur_length    <= cur_length_next;
      first_byte    <= first_byte_next;
      second_byte   <= second_byte_next;
      dot_offset    <= dot_offset_next;
      dot_found     <= dot_found_next;
      brace_nesting <= brace_nesting_next;
      brace_balance <= brace_balance_next;
      first_pending <= first_pending_next;
      stopped       <= stopped_next;
    end
  end

  // A pair of results is always a composed head followed by its tail
  `LTG_ASSERT_HOLDS(a_pair_is_split, clk, rst,
    (n != 2'd2) ||
    ((r0.token_kind == ltg_pkg::KIND_HEAD) && (r1.token_kind == ltg_pkg::KIND_TAIL)))
  // Brace error only appears on the line-end result
  `LTG_ASSERT_HOLDS(a_err_with_done, clk, rst,
    (!r0.brace_error || r0.line_done) && (!r1.brace_error || r1.line_done))
  // Last byte of a line returns the line state to its start
  `LTG_ASSERT_NEXT(a_line_restart, clk, rst, take && last_char,
    (pos == '0) && first_pending && !stopped && (brace_balance == '0))

endmodule

`default_nettype wire

// ----- sv/ltg_result_queue.sv -----
// ----------------------------------------------------------------------------
// Line tokenizer result queue
// Small queue taking up to two results per cycle and giving one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_tokenizer_with_groups_core_macros.svh"

module ltg_result_queue (
  input  logic           clk,
  input  logic           rst,
  input  ltg_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output ltg_pkg::res_t  head
);

  ltg_pkg::res_t mem [ltg_pkg::QDEPTH];

  logic [ltg_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ltg_pkg::QCNT_W-1:0] count;
  logic                       pop;

  assign space     = (count <= ltg_pkg::QCNT_W'(ltg_pkg::QDEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + ltg_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ltg_pkg::QPTR_W'(push.count);
      rd_ptr <= rd_ptr + ltg_pkg::QPTR_W'(pop);
      count  <= count + ltg_pkg::QCNT_W'(push.count) - ltg_pkg::QCNT_W'(pop);
    end
  end

  `LTG_ASSERT_HOLDS(a_no_overfill, clk, rst, count <= ltg_pkg::QCNT_W'(ltg_pkg::QDEPTH))
  `LTG_ASSERT_HOLDS(a_push_has_room, clk, rst,
    (push.count == 2'd0) || space)
  `LTG_ASSERT_NEXT(a_head_held, clk, rst, out_valid && !out_ready, $stable(head))

endmodule

`default_nettype wire

// ----- sv/line_tokenizer_with_groups_core.sv -----
// ----------------------------------------------------------------------------
// Line tokenizer with groups, top level
// Output: each result enters the result queue at the byte transfer that causes it.
// Throughput: one byte per cycle; a byte that yields a composed head and tail
//   gives two results on the output, and input stalls while fewer than two of the four
//   result queue slots are free.
// Reset: synchronous; clears line state and the result queue, sets separator to
//   space and turns composing on.
// ----------------------------------------------------------------------------
`default_nettype none

module line_tokenizer_with_groups_core (
  input  logic        clk,
  input  logic        rst,
  // Byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        token_valid,
  output logic [9:0]  token_offset,
  output logic [10:0] token_length,
  output logic [2:0]  token_kind,
  output logic        line_done,
  output logic        brace_error,
  output logic        last_result,
  // Configuration writes
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  ltg_pkg::cfg_t  cfg;
  ltg_pkg::push_t push;
  ltg_pkg::res_t  head;
  logic           take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator      <= ltg_pkg::SEP_RESET;
      cfg.allow_composed <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        ltg_pkg::REG_SEPARATOR:      cfg.separator      <= cfg_data;
        ltg_pkg::REG_ALLOW_COMPOSED: cfg.allow_composed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign take = in_valid && in_ready;

  ltg_tokenizer u_tokenizer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push)
  );

  ltg_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields
  assign token_valid  = head.token_valid;
  assign token_offset = head.token_offset;
  assign token_length = head.token_length;
  assign token_kind   = head.token_kind;
  assign line_done    = head.line_done;
  assign brace_error  = head.brace_error;
  assign last_result  = head.last_result;

endmodule

`default_nettype wire
